[rtl/core/fcgi_pkg.sv]
package fcgi_pkg;

  // Record types and field values that the deframer reacts to.
  localparam logic [7:0]  TYPE_BEGIN_REQUEST = 8'd1;
  localparam logic [7:0]  TYPE_PARAMS        = 8'd4;
  localparam logic [7:0]  TYPE_STDIN         = 8'd5;
  localparam logic [15:0] ROLE_RESPONDER     = 16'd1;
  localparam logic [7:0]  FLAG_KEEP_CONN     = 8'd1;
  localparam logic [15:0] BEGIN_BODY_LEN     = 16'd8;

  // Classification of each byte of the stream.
  localparam logic [1:0] CLS_HEADER  = 2'd0;
  localparam logic [1:0] CLS_CONTENT = 2'd1;
  localparam logic [1:0] CLS_PADDING = 2'd2;

  typedef struct packed {
    logic [1:0]  byte_class;
    logic [7:0]  record_type;
    logic [15:0] request_id;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        payload_stream;
    logic        record_last;
    logic        stream_end;
    logic        begin_accepted;
    logic        keep_conn;
    logic        request_ready;
  } fcgi_result_t;

endpackage

[rtl/core/fcgi_step.sv]
module fcgi_step (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [7:0]            stream_byte_i,
  output fcgi_pkg::fcgi_result_t result_o
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_CONTENT = 2'd1;
  localparam logic [1:0] PH_PADDING = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [2:0]  hidx_q, hidx_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] id_q, id_d;
  logic [15:0] clen_q, clen_d;
  logic [15:0] cleft_q, cleft_d;
  logic [7:0]  pleft_q, pleft_d;
  logic [15:0] role_q, role_d;
  logic [7:0]  flags_q, flags_d;
  logic        keep_q, keep_d;
  logic        ready_q, ready_d;

  logic [15:0] offset;
  logic        is_stream;
  logic        finish;
  logic        s_end;
  logic        accepted;
  logic        last;
  logic [1:0]  cls;
  logic        pvalid;

  assign offset    = clen_q - cleft_q;
  assign is_stream = (type_q == fcgi_pkg::TYPE_PARAMS) || (type_q == fcgi_pkg::TYPE_STDIN);

  always_comb begin
    phase_d = phase_q;
    hidx_d  = hidx_q;
    type_d  = type_q;
    id_d    = id_q;
    clen_d  = clen_q;
    cleft_d = cleft_q;
    pleft_d = pleft_q;
    role_d  = role_q;
    flags_d = flags_q;
    cls     = fcgi_pkg::CLS_HEADER;
    pvalid  = 1'b0;
    last    = 1'b0;
    case (phase_q)
      PH_CONTENT: begin
        cls    = fcgi_pkg::CLS_CONTENT;
        pvalid = is_stream;
        if (type_q == fcgi_pkg::TYPE_BEGIN_REQUEST) begin
          if (offset == 16'd0) begin
            role_d = {stream_byte_i, role_q[7:0]};
          end else if (offset == 16'd1) begin
            role_d = {role_q[15:8], stream_byte_i};
          end else if (offset == 16'd2) begin
            flags_d = stream_byte_i;
          end
        end
        cleft_d = cleft_q - 16'd1;
        if (cleft_d == 16'd0) begin
          if (pleft_q != 8'd0) begin
            phase_d = PH_PADDING;
          end else begin
            last = 1'b1;
          end
        end
      end
      PH_PADDING: begin
        cls     = fcgi_pkg::CLS_PADDING;
        pleft_d = pleft_q - 8'd1;
        if (pleft_d == 8'd0) begin
          last = 1'b1;
        end
      end
      default: begin
        // The unused phase code behaves as header phase.
        case (hidx_q)
          3'd1:    type_d  = stream_byte_i;
          3'd2:    id_d    = {stream_byte_i, 8'd0};
          3'd3:    id_d    = {id_q[15:8], stream_byte_i};
          3'd4:    clen_d  = {stream_byte_i, 8'd0};
          3'd5:    clen_d  = {clen_q[15:8], stream_byte_i};
          3'd6:    pleft_d = stream_byte_i;
          default: ;
        endcase
        phase_d = PH_HEADER;
        hidx_d  = hidx_q + 3'd1;
        if (hidx_q == 3'd7) begin
          cleft_d = clen_q;
          hidx_d  = 3'd0;
          if (clen_q != 16'd0) begin
            phase_d = PH_CONTENT;
          end else if (pleft_q != 8'd0) begin
            phase_d = PH_PADDING;
          end else begin
            last = 1'b1;
          end
        end
      end
    endcase

    finish   = last;
    s_end    = finish && (clen_d == 16'd0) &&
               ((type_d == fcgi_pkg::TYPE_PARAMS) || (type_d == fcgi_pkg::TYPE_STDIN));
    accepted = finish && (type_d == fcgi_pkg::TYPE_BEGIN_REQUEST) &&
               (clen_d >= fcgi_pkg::BEGIN_BODY_LEN) && (role_d == fcgi_pkg::ROLE_RESPONDER);
    keep_d   = accepted ? (flags_d == fcgi_pkg::FLAG_KEEP_CONN) : keep_q;
    ready_d  = ready_q || (s_end && (type_d == fcgi_pkg::TYPE_STDIN));
    if (finish) begin
      phase_d = PH_HEADER;
      hidx_d  = 3'd0;
    end
  end

  always_comb begin
    result_o.byte_class     = cls;
    result_o.record_type    = type_d;
    result_o.request_id     = id_d;
    result_o.payload_byte   = pvalid ? stream_byte_i : 8'd0;
    result_o.payload_valid  = pvalid;
    result_o.payload_stream = pvalid && (type_q == fcgi_pkg::TYPE_STDIN);
    result_o.record_last    = last;
    result_o.stream_end     = s_end;
    result_o.begin_accepted = accepted;
    result_o.keep_conn      = keep_d;
    result_o.request_ready  = ready_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      hidx_q  <= 3'd0;
      type_q  <= 8'd0;
      id_q    <= 16'd0;
      clen_q  <= 16'd0;
      cleft_q <= 16'd0;
      pleft_q <= 8'd0;
      role_q  <= 16'd0;
      flags_q <= 8'd0;
      keep_q  <= 1'b0;
      ready_q <= 1'b0;
    end else if (en_i) begin
      phase_q <= phase_d;
      hidx_q  <= hidx_d;
      type_q  <= type_d;
      id_q    <= id_d;
      clen_q  <= clen_d;
      cleft_q <= cleft_d;
      pleft_q <= pleft_d;
      role_q  <= role_d;
      flags_q <= flags_d;
      keep_q  <= keep_d;
      ready_q <= ready_d;
    end
  end

endmodule

[rtl/core/fastcgi_record_deframer.sv]
// FastCGI record deframer.
// The input channel (in_valid_i / in_ready_o / stream_byte_i) carries the
// record stream one byte per request. The output channel (out_valid_o /
// out_ready_i and the result ports) returns exactly one result per byte:
// its class, the current record type and id, the forwarded content byte of
// params and stdin records, and end-of-record, end-of-stream and
// begin-request markers together with the keep-connection and sticky
// request-ready flags.
// A byte is captured in an input register, then decoded against the
// record state by one level of logic into the result register. The result
// is shown once the byte has passed through the input register and the
// result register, and one byte is accepted every cycle while the receiver
// takes results.
// When the receiver stalls, the result register holds and one more byte
// may wait in the input register; after that in_ready_o drops until the
// result is taken.
// Reset clears the input valid flag and the result register and returns
// the parser to the start of a record header with all flags cleared.
module fastcgi_record_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  byte_class_o,
  output logic [7:0]  record_type_o,
  output logic [15:0] request_id_o,
  output logic [7:0]  payload_byte_o,
  output logic        payload_valid_o,
  output logic        payload_stream_o,
  output logic        record_last_o,
  output logic        stream_end_o,
  output logic        begin_accepted_o,
  output logic        keep_conn_o,
  output logic        request_ready_o
);

  logic                   in_vld_q;
  logic [7:0]             in_byte_q;
  logic                   out_vld_q;
  fcgi_pkg::fcgi_result_t res_q;
  fcgi_pkg::fcgi_result_t res_d;
  logic                   advance;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  fcgi_step u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .stream_byte_i (in_byte_q),
    .result_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= stream_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      res_q     <= '0;
    end else begin
      if (advance) begin
        out_vld_q <= 1'b1;
        res_q     <= res_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_vld_q;
  assign byte_class_o     = res_q.byte_class;
  assign record_type_o    = res_q.record_type;
  assign request_id_o     = res_q.request_id;
  assign payload_byte_o   = res_q.payload_byte;
  assign payload_valid_o  = res_q.payload_valid;
  assign payload_stream_o = res_q.payload_stream;
  assign record_last_o    = res_q.record_last;
  assign stream_end_o     = res_q.stream_end;
  assign begin_accepted_o = res_q.begin_accepted;
  assign keep_conn_o      = res_q.keep_conn;
  assign request_ready_o  = res_q.request_ready;

  a_payload_is_content: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && payload_valid_o |-> byte_class_o == fcgi_pkg::CLS_CONTENT)
    else $error("forwarded byte not classed as content");

  a_markers_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (stream_end_o || begin_accepted_o) |-> record_last_o)
    else $error("stream end or begin accept away from record end");

  a_ready_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(request_ready_o) |-> request_ready_o)
    else $error("request ready flag cleared");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(in_byte_q))
    else $error("waiting input byte lost");

endmodule
